@@ sv/lru_page_replacement_list_defines.svh @@
// assertion macros for the lru page replacement list
`ifndef LRU_PAGE_REPLACEMENT_LIST_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_LIST_DEFINES_SVH

// check on every rising clock edge outside reset
`define LRUPL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising clock edge, reset included
`define LRUPL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/lrupl_pkg.sv @@
// shared constants and command codes for the lru page replacement list
package lrupl_pkg;

  // page ids are four bits, so at most sixteen distinct pages exist
  localparam int PAGE_W        = 4;
  localparam int NUM_IDS       = 16;
  localparam int MAX_PAGES_DEF = 16;

  // stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_VICTIM = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

endpackage

@@ sv/lru_page_replacement_list.sv @@
// lru page replacement list: recency list of page ids held in a two-bank memory
//
// Input channel s_axis: tuser carries the command (access, victim, tick),
// tdata carries the page id and the visited mask. Output channel m_axis:
// one transaction per input transaction, tuser carries victim_found and
// status, tdata carries victim_page.
// An access, victim or tick on a non-empty list, if not dropped, rebuilds
// the list by walking the current memory bank one entry per cycle through
// the single read port and writing the kept entries in order into the other
// bank, then the banks swap. A tick walks the list in two passes
// (unvisited, then visited); a dropped access or an unused command skips
// the walk. The next transaction is accepted once the result has been
// placed in the output register, so the input side keeps moving while the
// receiver holds off one result.
// If the receiver stalls with a result still waiting, the block finishes the
// next command and then holds until the output register frees up.
// Reset (rst, synchronous) empties the list and clears the output valid; the
// memory contents need no clearing since only listed positions are read.
module lru_page_replacement_list #(
  parameter int MAX_PAGES = lrupl_pkg::MAX_PAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input transactions
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: page_id [3:0], visited_mask [19:4], zero fill [23:20]
  input  logic [lrupl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: command [1:0]
  input  logic [1:0]                     s_axis_tuser,
  // output transactions
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: victim_page [3:0], zero fill [7:4]
  output logic [lrupl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // tuser: victim_found [0], status [1]
  output logic [1:0]                     m_axis_tuser
);

  `include "lru_page_replacement_list_defines.svh"

  localparam int PW    = lrupl_pkg::PAGE_W;
  localparam int CAP   = (MAX_PAGES < lrupl_pkg::NUM_IDS) ? MAX_PAGES : lrupl_pkg::NUM_IDS;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int MEM_D = 2 * (1 << IDX_W);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_FIN   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                  state;
  lrupl_pkg::cmd_t         op;
  logic [PW-1:0]           pg;
  logic [lrupl_pkg::NUM_IDS-1:0] mask;
  logic                    err;
  logic                    bank;
  logic [CNT_W-1:0]        count;
  logic [lrupl_pkg::NUM_IDS-1:0] present_bits;
  logic [IDX_W-1:0]        rd_idx;
  logic                    pass;
  logic                    rd_vld;
  logic [IDX_W-1:0]        rd_pos;
  logic                    rd_pass;
  logic [PW-1:0]           rd_data;
  logic [CNT_W-1:0]        wptr;
  logic [PW-1:0]           head;
  logic                    res_found;
  logic [PW-1:0]           res_page;
  logic                    res_status;
  logic                    out_found;
  logic [PW-1:0]           out_page;
  logic                    out_status;

  logic [PW-1:0]           mem [MEM_D];

  logic                    s_acc;
  lrupl_pkg::cmd_t         in_cmd;
  logic [PW-1:0]           in_page;
  logic                    rd_en;
  logic [IDX_W:0]          rd_addr;
  logic                    keep;
  logic                    append;
  logic                    wr_en;
  logic [IDX_W:0]          wr_addr;
  logic [PW-1:0]           wr_data;
  logic                    rd_last;
  logic                    out_free;

  // input unpacking and handshakes
  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = lrupl_pkg::cmd_t'(s_axis_tuser);
  assign in_page       = s_axis_tdata[PW-1:0];
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // read side of the walk over the current bank
  assign rd_en   = (state == S_WALK);
  assign rd_addr = {bank, rd_idx};
  assign rd_last = (CNT_W'(rd_idx) == count - CNT_W'(1));

  // keep decision on the entry returned by the memory
  always_comb begin
    keep = 1'b0;
    if (rd_vld) begin
      case (op)
        lrupl_pkg::CMD_ACCESS: keep = (rd_data != pg);
        lrupl_pkg::CMD_VICTIM: keep = (rd_pos != '0);
        lrupl_pkg::CMD_TICK:   keep = (mask[rd_data] == rd_pass);
        default:               keep = 1'b0;
      endcase
    end
  end

  // write side into the other bank, accessed page appended last
  assign append  = (state == S_FIN) && (op == lrupl_pkg::CMD_ACCESS) && !err;
  assign wr_en   = keep || append;
  assign wr_addr = {~bank, wptr[IDX_W-1:0]};
  assign wr_data = append ? pg : rd_data;

  // list memory, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bank         <= 1'b0;
      count        <= '0;
      present_bits <= '0;
      rd_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld <= rd_en;

      // walk bookkeeping for each returned entry
      if (keep) begin
        wptr <= wptr + CNT_W'(1);
      end
      if (rd_vld && (op == lrupl_pkg::CMD_VICTIM) && (rd_pos == '0)) begin
        head <= rd_data;
      end

      // output valid: loaded from the sequencer, cleared when taken
      if ((state == S_OUT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            op      <= in_cmd;
            pg      <= in_page;
            mask    <= s_axis_tdata[PW +: lrupl_pkg::NUM_IDS];
            wptr    <= '0;
            rd_idx  <= '0;
            pass    <= 1'b0;
            err     <= (in_cmd == lrupl_pkg::CMD_ACCESS) && !present_bits[in_page] &&
                       (count == CNT_W'(CAP));
            if ((in_cmd == lrupl_pkg::CMD_ACCESS || in_cmd == lrupl_pkg::CMD_VICTIM ||
                 in_cmd == lrupl_pkg::CMD_TICK) && (count != '0) &&
                !((in_cmd == lrupl_pkg::CMD_ACCESS) && !present_bits[in_page] &&
                  (count == CNT_W'(CAP)))) begin
              state <= S_WALK;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_WALK: begin
          rd_pos  <= rd_idx;
          rd_pass <= pass;
          if (rd_last) begin
            if ((op == lrupl_pkg::CMD_TICK) && !pass) begin
              pass   <= 1'b1;
              rd_idx <= '0;
            end else begin
              state <= S_DRAIN;
            end
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          res_found  <= 1'b0;
          res_page   <= '0;
          res_status <= err;
          case (op)
            lrupl_pkg::CMD_ACCESS: begin
              if (!err) begin
                count            <= wptr + CNT_W'(1);
                present_bits[pg] <= 1'b1;
                bank             <= ~bank;
              end
            end
            lrupl_pkg::CMD_VICTIM: begin
              if (count != '0) begin
                count              <= count - CNT_W'(1);
                present_bits[head] <= 1'b0;
                bank               <= ~bank;
                res_found          <= 1'b1;
                res_page           <= head;
              end
            end
            lrupl_pkg::CMD_TICK: begin
              bank <= ~bank;
            end
            default: begin
            end
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_found     <= res_found;
            out_page      <= res_page;
            out_status    <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output packing
  assign m_axis_tdata = {(lrupl_pkg::M_TDATA_W - PW)'(0), out_page};
  assign m_axis_tuser = {out_status, out_found};

  // checks on the list bookkeeping
  `LRUPL_ASSERT(a_count_cap, (count <= CNT_W'(CAP)), "entry count above capacity")
  `LRUPL_ASSERT(a_present_count,
                (state == S_IDLE) |-> ($countones(present_bits) == count),
                "present bits disagree with entry count")
  `LRUPL_ASSERT(a_wr_in_range, wr_en |-> (wptr < CNT_W'(CAP)), "write past list capacity")
  `LRUPL_ASSERT_ALWAYS(a_out_from_seq, $rose(m_axis_tvalid) |-> $past(state == S_OUT),
                       "result offered outside output state")

endmodule

@@ tb/sv/tb_lru_page_replacement_list.sv @@
// self-checking testbench for the lru page replacement list stream block
module tb_lru_page_replacement_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = lrupl_pkg::MAX_PAGES_DEF;
  localparam int NUM_IDS      = lrupl_pkg::NUM_IDS;
  localparam int LIST_CAP     = (LIST_DEPTH < NUM_IDS) ? LIST_DEPTH : NUM_IDS;
  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * NUM_IDS + 20;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  page;
    logic [15:0] mask;
  } page_cmd_t;

  typedef struct packed {
    logic       found;
    logic [3:0] page;
    logic       status;
  } lru_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lrupl_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [1:0]                      s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lrupl_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                      m_axis_tuser;

  // pending commands and predicted results
  page_cmd_t   pending_cmds[$];
  lru_result_t expected_results[$];

  // predictor copy of the recency list
  logic [3:0]  lru_order[NUM_IDS];
  int          lru_count   = 0;
  logic [15:0] lru_present = '0;

  int  err_count   = 0;
  int  sent_count  = 0;
  int  stall_count = 0;
  bit  in_fire     = 1'b0;

  lru_page_replacement_list #(
    .MAX_PAGES(LIST_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // page_id [3:0], visited_mask [19:4], zero [23:20]
    .s_axis_tuser (s_axis_tuser),   // command [1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // victim_page [3:0], zero [7:4]
    .m_axis_tuser (m_axis_tuser)    // victim_found [0], status [1]
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the predicted list and return its result
  function automatic lru_result_t lru_apply(input logic [1:0] cmd, input logic [3:0] pg,
                                            input logic [15:0] mask);
    lru_result_t res;
    logic [3:0]  head;
    logic [3:0]  sorted[NUM_IDS];
    int          pos;
    int          n;
    res = '0;
    pos = 0;
    n   = 0;
    case (cmd)
      lrupl_pkg::CMD_ACCESS: begin
        if (lru_present[pg]) begin
          // hit: move the page to the tail
          while (lru_order[pos] != pg) pos++;
          for (int i = pos; i < lru_count - 1; i++) lru_order[i] = lru_order[i + 1];
          lru_order[lru_count - 1] = pg;
        end else if (lru_count >= LIST_CAP) begin
          res.status = 1'b1;
        end else begin
          lru_order[lru_count] = pg;
          lru_count++;
          lru_present[pg] = 1'b1;
        end
      end
      lrupl_pkg::CMD_VICTIM: begin
        if (lru_count > 0) begin
          head = lru_order[0];
          for (int i = 0; i < lru_count - 1; i++) lru_order[i] = lru_order[i + 1];
          lru_count--;
          lru_present[head] = 1'b0;
          res.found = 1'b1;
          res.page  = head;
        end
      end
      lrupl_pkg::CMD_TICK: begin
        // stable split: unvisited pages first, then visited ones
        for (int i = 0; i < lru_count; i++)
          if (!mask[lru_order[i]]) begin
            sorted[n] = lru_order[i];
            n++;
          end
        for (int i = 0; i < lru_count; i++)
          if (mask[lru_order[i]]) begin
            sorted[n] = lru_order[i];
            n++;
          end
        for (int i = 0; i < n; i++) lru_order[i] = sorted[i];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    bit          out_fire;
    in_fire  = !rst && s_axis_tvalid && s_axis_tready;
    out_fire = !rst && m_axis_tvalid && m_axis_tready;
    if (in_fire) begin
      expected_results.push_back(lru_apply(s_axis_tuser, s_axis_tdata[3:0],
                                           s_axis_tdata[19:4]));
      sent_count++;
    end
    if (out_fire) begin
      got.found  = m_axis_tuser[0];
      got.status = m_axis_tuser[1];
      got.page   = m_axis_tdata[3:0];
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: found %0d page %0d status %0d",
                 $time, got.found, got.page, got.status);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: victim_found expected %0d actual %0d", $time, want.found, got.found);
          err_count++;
        end
        if (got.page !== want.page) begin
          $display("%0t: victim_page expected %0d actual %0d", $time, want.page, got.page);
          err_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          err_count++;
        end
      end
    end
    // watchdog on cycles with no transaction on either side
    if (rst || in_fire || out_fire) stall_count = 0;
    else stall_count++;
  end

  // driver: feeds pending commands and randomizes both sides' idling
  always @(negedge clk) begin
    page_cmd_t item;
    int        send_pct;
    int        recv_pct;
    case ((sent_count / 100) % 4)
      0: begin send_pct = 0;  recv_pct = 0;  end
      1: begin send_pct = 60; recv_pct = 0;  end
      2: begin send_pct = 0;  recv_pct = 60; end
      default: begin send_pct = 19; recv_pct = 19; end
    endcase
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && !in_fire) begin
        // hold the offered transaction
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_pct) begin
        item = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.cmd;
        s_axis_tdata  <= {4'b0, item.mask, item.page};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // queue one command
  task automatic queue_cmd(input logic [1:0] cmd, input logic [3:0] pg, input logic [15:0] mask);
    page_cmd_t item;
    item.cmd  = cmd;
    item.page = pg;
    item.mask = mask;
    pending_cmds.push_back(item);
  endtask

  // stimulus, reset and end of run
  initial begin
    int  acc_pct;
    int  r;
    int  mask_sel;
    logic [1:0]  cmd;
    logic [15:0] mask;
    bit  timed_out;

    // directed: empty list cases, unused command, repeated access
    queue_cmd(lrupl_pkg::CMD_VICTIM, 4'hF, 16'hFFFF);
    queue_cmd(lrupl_pkg::CMD_TICK, 4'h0, 16'hFFFF);
    queue_cmd(CMD_UNUSED, 4'hF, 16'hFFFF);
    queue_cmd(lrupl_pkg::CMD_ACCESS, 4'h0, 16'h0000);
    queue_cmd(lrupl_pkg::CMD_ACCESS, 4'hF, 16'h0000);
    queue_cmd(lrupl_pkg::CMD_ACCESS, 4'h0, 16'hFFFF);
    queue_cmd(lrupl_pkg::CMD_TICK, 4'h3, 16'h0001);
    // fill the list to capacity, then hit it while full
    for (int p = NUM_IDS - 1; p >= 0; p--) queue_cmd(lrupl_pkg::CMD_ACCESS, p[3:0], 16'h0000);
    queue_cmd(lrupl_pkg::CMD_ACCESS, 4'h7, 16'h0000);
    queue_cmd(lrupl_pkg::CMD_TICK, 4'h0, 16'h5555);
    queue_cmd(lrupl_pkg::CMD_VICTIM, 4'h0, 16'h0000);

    // random: blocks biased toward growing or draining the list
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(2))
          0: acc_pct = 30;
          1: acc_pct = 50;
          default: acc_pct = 70;
        endcase
      end
      r = $urandom_range(99);
      if (r < acc_pct) cmd = lrupl_pkg::CMD_ACCESS;
      else if (r < 95) cmd = (r % 2) ? lrupl_pkg::CMD_VICTIM : lrupl_pkg::CMD_TICK;
      else cmd = CMD_UNUSED;
      mask_sel = $urandom_range(3);
      case (mask_sel)
        0: mask = 16'h0000;
        1: mask = 16'hFFFF;
        default: mask = 16'($urandom());
      endcase
      queue_cmd(cmd, 4'($urandom_range(15)), mask);
    end

    // hold reset, then release it
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for everything to drain
    timed_out = 1'b0;
    while (!timed_out && (pending_cmds.size() > 0 || s_axis_tvalid ||
                          expected_results.size() > 0)) begin
      @(posedge clk);
      if (stall_count >= STALL_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);

    if (!timed_out && err_count == 0 && expected_results.size() == 0) begin
      $display("[lru_page_replacement_list] OK");
    end else begin
      $display("[lru_page_replacement_list] ERROR");
    end
    $finish;
  end

endmodule

@@ lru_page_replacement_list.f @@
+incdir+sv
sv/lrupl_pkg.sv
sv/lru_page_replacement_list.sv
tb/sv/tb_lru_page_replacement_list.sv
